// ===== rtl/core/slex_pkg.sv =====
// slex_pkg: shared types, token kind codes and character-class helpers for the
// script lexer. Depends on nothing; imported by rtl/core/script_lexer.sv.
package slex_pkg;

    // Input beat: one source byte and its end-of-source flag.
    typedef struct packed {
        logic [7:0] ch;
        logic       end_of_source;
    } t_lex_in;

    // Output beat: one token.
    typedef struct packed {
        logic [4:0]  token_kind;
        logic [15:0] start_pos;
        logic [7:0]  length;
        logic [31:0] number_value;
        logic        too_long;
        logic        last_of_run;
    } t_lex_out;

    typedef enum logic [2:0] {
        MODE_DEFAULT = 3'd0,
        MODE_OP      = 3'd1,
        MODE_NUM     = 3'd2,
        MODE_ID      = 3'd3,
        MODE_STR     = 3'd4
    } t_lex_mode;

    localparam logic [4:0] TK_PLUS     = 5'd0;
    localparam logic [4:0] TK_MINUS    = 5'd1;
    localparam logic [4:0] TK_STAR     = 5'd2;
    localparam logic [4:0] TK_SLASH    = 5'd3;
    localparam logic [4:0] TK_PERCENT  = 5'd4;
    localparam logic [4:0] TK_LT       = 5'd5;
    localparam logic [4:0] TK_LE       = 5'd6;
    localparam logic [4:0] TK_GT       = 5'd7;
    localparam logic [4:0] TK_GE       = 5'd8;
    localparam logic [4:0] TK_ASSIGN   = 5'd9;
    localparam logic [4:0] TK_EQ       = 5'd10;
    localparam logic [4:0] TK_NOT      = 5'd11;
    localparam logic [4:0] TK_NE       = 5'd12;
    localparam logic [4:0] TK_OR       = 5'd13;
    localparam logic [4:0] TK_AND      = 5'd14;
    localparam logic [4:0] TK_LPAREN   = 5'd15;
    localparam logic [4:0] TK_RPAREN   = 5'd16;
    localparam logic [4:0] TK_LBRACKET = 5'd17;
    localparam logic [4:0] TK_RBRACKET = 5'd18;
    localparam logic [4:0] TK_COMMA    = 5'd19;
    localparam logic [4:0] TK_STRING   = 5'd20;
    localparam logic [4:0] TK_NUMBER   = 5'd21;
    localparam logic [4:0] TK_IDENT    = 5'd22;
    localparam logic [4:0] TK_SCRIPT   = 5'd23;
    localparam logic [4:0] TK_END      = 5'd24;
    localparam logic [4:0] TK_WHILE    = 5'd25;
    localparam logic [4:0] TK_IF       = 5'd26;
    localparam logic [4:0] TK_ELSE     = 5'd27;
    localparam logic [4:0] TK_DEF      = 5'd28;
    localparam logic [4:0] TK_MAX      = TK_DEF;

    localparam int PREFIX_DEPTH = 6;

    // Result queue between the lex stage and the output port.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    typedef logic [0:PREFIX_DEPTH-1][7:0] t_prefix;

    function automatic logic is_op(input logic [7:0] c);
        return c == "+" || c == "-" || c == "*" || c == "/" || c == "%" ||
               c == "<" || c == ">" || c == "=" || c == "!" || c == "|" ||
               c == "&";
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_punct(input logic [7:0] c);
        return c == "(" || c == ")" || c == "[" || c == "]" || c == ",";
    endfunction

    function automatic logic [4:0] punct_kind(input logic [7:0] c);
        logic [4:0] k;
        case (c)
            "(":     k = TK_LPAREN;
            ")":     k = TK_RPAREN;
            "[":     k = TK_LBRACKET;
            "]":     k = TK_RBRACKET;
            default: k = TK_COMMA;
        endcase
        return k;
    endfunction

    // Bytes whose kind a trailing '=' refines.
    function automatic logic refines(input logic [7:0] c);
        return c == "<" || c == ">" || c == "=" || c == "!";
    endfunction

    function automatic logic [4:0] op_kind(input logic [7:0] first, input logic refined);
        logic [4:0] k;
        case (first)
            "+":     k = TK_PLUS;
            "-":     k = TK_MINUS;
            "*":     k = TK_STAR;
            "/":     k = TK_SLASH;
            "%":     k = TK_PERCENT;
            "<":     k = refined ? TK_LE : TK_LT;
            ">":     k = refined ? TK_GE : TK_GT;
            "=":     k = refined ? TK_EQ : TK_ASSIGN;
            "!":     k = refined ? TK_NE : TK_NOT;
            "|":     k = TK_OR;
            default: k = TK_AND;
        endcase
        return k;
    endfunction

    // len_code is the word length when below 8, else 7 (matches no word).
    function automatic logic [4:0] word_kind(input t_prefix p, input logic [2:0] len_code);
        logic [4:0] k;
        k = TK_IDENT;
        if (len_code == 3'd6 && p[0:5] == "script") begin
            k = TK_SCRIPT;
        end else if (len_code == 3'd3 && p[0:2] == "end") begin
            k = TK_END;
        end else if (len_code == 3'd5 && p[0:4] == "while") begin
            k = TK_WHILE;
        end else if (len_code == 3'd2 && p[0:1] == "if") begin
            k = TK_IF;
        end else if (len_code == 3'd4 && p[0:3] == "else") begin
            k = TK_ELSE;
        end else if (len_code == 3'd3 && p[0:2] == "def") begin
            k = TK_DEF;
        end
        return k;
    endfunction

endpackage

// ===== rtl/core/script_lexer.sv =====
// script_lexer: byte-stream lexer for a small scripting language.
// Depends on rtl/core/slex_pkg.sv (beat types, token kinds, character classes).

// The lexer takes one source byte per input beat and delivers tokens on the
// output channel, one token per beat. A byte passes through an input register,
// then through classification against the current lexing mode,
// which updates the mode state and pushes zero, one or two tokens into a
// four-entry result queue that drives the output port. A byte that ends a
// pending number, identifier or operator is classified again in the default
// mode in the same cycle, so one byte can yield two tokens; the last token
// caused by a byte carries last_of_run. The input side takes one byte every
// cycle as long as the queue has room for two more tokens after this cycle's
// pop, so the sustained rate is one byte per cycle while the consumer keeps
// up, bounded by one token per cycle on the output port. A byte's tokens are
// written into the queue from the input register, and the port shows the
// queue's head entry. end_of_source on a byte flushes any pending token after
// it and restarts the position count at zero; an unterminated string is
// dropped at that point. Token text is described by start position and
// length; the length saturates at MAX_TEXT_LEN (and at 255), with too_long
// set when the text ran over.
module script_lexer #(
    parameter int MAX_TEXT_LEN = 255,
    parameter int POS_BITS     = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  slex_pkg::t_lex_in  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output slex_pkg::t_lex_out o_out_data
);
    import slex_pkg::*;

    // Text counter holds up to MAX_TEXT_LEN+1 so that overrun is visible.
    localparam int LEN_W = $clog2(MAX_TEXT_LEN + 2);
    localparam int CNT_W = QUEUE_AW + 1;

    // ---------------------------------------------------------------
    // Input register
    // ---------------------------------------------------------------
    logic    r_in_valid;
    t_lex_in r_in;
    logic    w_room;
    logic    w_fire;

    assign o_in_stall = r_in_valid && !w_room;
    assign w_fire     = r_in_valid && w_room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_data;
        end
    end

    // ---------------------------------------------------------------
    // Lexer state
    // ---------------------------------------------------------------
    t_lex_mode           r_mode,          n_mode;
    logic [7:0]          r_first_op,      n_first_op;
    logic                r_op_has_second, n_op_has_second;
    logic                r_op_refined,    n_op_refined;
    logic [LEN_W-1:0]    r_text_length,   n_text_length;
    t_prefix             r_word_prefix,   n_word_prefix;
    logic [31:0]         r_number_accum,  n_number_accum;
    logic [POS_BITS-1:0] r_token_start,   n_token_start;
    logic [POS_BITS-1:0] r_byte_position, n_byte_position;

    // ---------------------------------------------------------------
    // Byte classification
    // ---------------------------------------------------------------
    logic [7:0]          w_ch;
    logic                w_eos;
    logic                w_is_op;
    logic                w_digit;
    logic                w_alpha;
    logic                w_punct;
    logic                w_quote;
    logic [LEN_W-1:0]    w_len_up;
    logic [35:0]         w_acc_wide;
    logic [31:0]         w_acc_next;
    logic [POS_BITS-1:0] w_pos_next;
    logic                w_pass1_emit;
    logic                w_run_default;
    t_lex_mode           w_default_mode;
    t_lex_mode           w_mid_mode;

    assign w_ch    = r_in.ch;
    assign w_eos   = r_in.end_of_source;
    assign w_is_op = is_op(w_ch);
    assign w_digit = is_digit(w_ch);
    assign w_alpha = is_alpha(w_ch);
    assign w_punct = is_punct(w_ch);
    assign w_quote = (w_ch == "\"");

    // Count a text byte, stopping one past the limit.
    assign w_len_up = (r_text_length <= LEN_W'(MAX_TEXT_LEN)) ?
                      r_text_length + LEN_W'(1) : r_text_length;

    // accum*10 + digit as shifts and adds, then saturate.
    assign w_acc_wide = ({4'b0, r_number_accum} << 3) + ({4'b0, r_number_accum} << 1) +
                        {32'b0, w_ch[3:0]};
    assign w_acc_next = (w_acc_wide[35:32] != 4'b0) ? 32'hFFFF_FFFF : w_acc_wide[31:0];

    assign w_pos_next = r_byte_position + POS_BITS'(1);

    // First pass: does the byte end the pending token?
    always_comb begin
        case (r_mode)
            MODE_OP:  w_pass1_emit = !(w_is_op && !r_op_has_second);
            MODE_NUM: w_pass1_emit = !w_digit;
            MODE_ID:  w_pass1_emit = !(w_alpha || w_digit);
            MODE_STR: w_pass1_emit = w_quote;
            default:  w_pass1_emit = 1'b0;
        endcase
    end

    // Second pass in the default mode, either directly or after a token ended
    // (a closing quote is consumed and does not go around again).
    assign w_run_default = !(r_mode == MODE_OP || r_mode == MODE_NUM ||
                             r_mode == MODE_ID || r_mode == MODE_STR) ||
                           (w_pass1_emit && r_mode != MODE_STR);

    always_comb begin
        if (w_is_op) begin
            w_default_mode = MODE_OP;
        end else if (w_digit) begin
            w_default_mode = MODE_NUM;
        end else if (w_alpha) begin
            w_default_mode = MODE_ID;
        end else if (w_quote) begin
            w_default_mode = MODE_STR;
        end else begin
            w_default_mode = MODE_DEFAULT;
        end
    end

    // Mode after both passes, before the end-of-source flush.
    always_comb begin
        if (w_run_default) begin
            w_mid_mode = w_default_mode;
        end else if (r_mode == MODE_STR && w_quote) begin
            w_mid_mode = MODE_DEFAULT;
        end else begin
            w_mid_mode = r_mode;
        end
    end

    // ---------------------------------------------------------------
    // Next state
    // ---------------------------------------------------------------
    always_comb begin
        n_first_op      = r_first_op;
        n_op_has_second = r_op_has_second;
        n_op_refined    = r_op_refined;
        n_text_length   = r_text_length;
        n_word_prefix   = r_word_prefix;
        n_number_accum  = r_number_accum;
        n_token_start   = r_token_start;

        case (r_mode)
            MODE_OP: begin
                if (w_is_op && !r_op_has_second) begin
                    n_op_has_second = 1'b1;
                    n_op_refined    = (w_ch == "=") && refines(r_first_op);
                end
            end
            MODE_NUM: begin
                if (w_digit) begin
                    n_number_accum = w_acc_next;
                    n_text_length  = w_len_up;
                end
            end
            MODE_ID: begin
                if (w_alpha || w_digit) begin
                    if (r_text_length < LEN_W'(PREFIX_DEPTH)) begin
                        n_word_prefix[r_text_length[2:0]] = w_ch;
                    end
                    n_text_length = w_len_up;
                end
            end
            MODE_STR: begin
                if (!w_quote) begin
                    n_text_length = w_len_up;
                end
            end
            default: ;
        endcase

        if (w_run_default) begin
            if (w_is_op) begin
                n_first_op      = w_ch;
                n_op_has_second = 1'b0;
                n_op_refined    = 1'b0;
                n_token_start   = r_byte_position;
            end else if (w_digit) begin
                n_number_accum = {28'b0, w_ch[3:0]};
                n_text_length  = LEN_W'(1);
                n_token_start  = r_byte_position;
            end else if (w_alpha) begin
                n_word_prefix[0] = w_ch;
                n_text_length    = LEN_W'(1);
                n_token_start    = r_byte_position;
            end else if (w_quote) begin
                n_text_length = '0;
                n_token_start = w_pos_next;
            end
        end

        n_mode          = w_eos ? MODE_DEFAULT : w_mid_mode;
        n_byte_position = w_eos ? '0 : w_pos_next;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode          <= MODE_DEFAULT;
            r_first_op      <= '0;
            r_op_has_second <= 1'b0;
            r_op_refined    <= 1'b0;
            r_text_length   <= '0;
            r_number_accum  <= '0;
            r_token_start   <= '0;
            r_byte_position <= '0;
        end else if (w_fire) begin
            r_mode          <= n_mode;
            r_first_op      <= n_first_op;
            r_op_has_second <= n_op_has_second;
            r_op_refined    <= n_op_refined;
            r_text_length   <= n_text_length;
            r_number_accum  <= n_number_accum;
            r_token_start   <= n_token_start;
            r_byte_position <= n_byte_position;
        end
    end

    // Prefix bytes are only read below the text length; no reset needed.
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_word_prefix <= n_word_prefix;
        end
    end

    // ---------------------------------------------------------------
    // Token outputs
    // ---------------------------------------------------------------
    function automatic logic [15:0] pos16(input logic [POS_BITS-1:0] p);
        logic [POS_BITS+15:0] wide;
        wide = {16'b0, p};
        return wide[15:0];
    endfunction

    function automatic logic [7:0] text_len8(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] capped;
        logic [LEN_W+7:0] wide;
        capped = (len > LEN_W'(MAX_TEXT_LEN)) ? LEN_W'(MAX_TEXT_LEN) : len;
        wide   = {8'b0, capped};
        return (wide > (LEN_W + 8)'(255)) ? 8'hFF : wide[7:0];
    endfunction

    function automatic logic [2:0] len_code(input logic [LEN_W-1:0] len);
        return (len < LEN_W'(7)) ? len[2:0] : 3'd7;
    endfunction

    t_lex_out w_tok_end;     // token ended by this byte
    t_lex_out w_tok_tail;    // punctuation or end-of-source flush
    logic     w_end_valid;
    logic     w_tail_valid;
    t_lex_out w_slot0;
    t_lex_out w_slot1;
    logic [1:0] w_push_cnt;

    always_comb begin
        w_end_valid             = w_pass1_emit;
        w_tok_end               = '0;
        w_tok_end.start_pos     = pos16(r_token_start);
        w_tok_end.length        = text_len8(r_text_length);
        w_tok_end.too_long      = r_text_length > LEN_W'(MAX_TEXT_LEN);
        case (r_mode)
            MODE_OP: begin
                w_tok_end.token_kind = op_kind(r_first_op, r_op_refined);
                w_tok_end.length     = r_op_has_second ? 8'd2 : 8'd1;
                w_tok_end.too_long   = 1'b0;
            end
            MODE_NUM: begin
                w_tok_end.token_kind   = TK_NUMBER;
                w_tok_end.number_value = r_number_accum;
            end
            MODE_ID: begin
                w_tok_end.token_kind = word_kind(r_word_prefix, len_code(r_text_length));
            end
            default: begin
                w_tok_end.token_kind = TK_STRING;
            end
        endcase

        // Flush uses the state as left by both passes.
        w_tok_tail           = '0;
        w_tok_tail.start_pos = pos16(n_token_start);
        w_tok_tail.length    = text_len8(n_text_length);
        w_tok_tail.too_long  = n_text_length > LEN_W'(MAX_TEXT_LEN);
        w_tail_valid         = 1'b0;
        if (w_run_default && w_punct) begin
            w_tail_valid          = 1'b1;
            w_tok_tail.token_kind = punct_kind(w_ch);
            w_tok_tail.start_pos  = pos16(r_byte_position);
            w_tok_tail.length     = 8'd1;
            w_tok_tail.too_long   = 1'b0;
        end else if (w_eos) begin
            case (w_mid_mode)
                MODE_OP: begin
                    w_tail_valid          = 1'b1;
                    w_tok_tail.token_kind = op_kind(n_first_op, n_op_refined);
                    w_tok_tail.length     = n_op_has_second ? 8'd2 : 8'd1;
                    w_tok_tail.too_long   = 1'b0;
                end
                MODE_NUM: begin
                    w_tail_valid            = 1'b1;
                    w_tok_tail.token_kind   = TK_NUMBER;
                    w_tok_tail.number_value = n_number_accum;
                end
                MODE_ID: begin
                    w_tail_valid          = 1'b1;
                    w_tok_tail.token_kind = word_kind(n_word_prefix,
                                                      len_code(n_text_length));
                end
                default: ;  // drop an open string
            endcase
        end

        // Order: ended token first, then the tail token.
        w_slot0 = w_end_valid ? w_tok_end : w_tok_tail;
        w_slot1 = w_tok_tail;
        w_slot0.last_of_run = !(w_end_valid && w_tail_valid);
        w_slot1.last_of_run = 1'b1;
        w_push_cnt = {1'b0, w_end_valid} + {1'b0, w_tail_valid};
    end

    // ---------------------------------------------------------------
    // Result queue
    // ---------------------------------------------------------------
    t_lex_out            r_q [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_head;
    logic [QUEUE_AW-1:0] r_tail;
    logic [CNT_W-1:0]    r_count;
    logic                w_pop;
    logic [CNT_W-1:0]    w_count_after_pop;
    logic [1:0]          w_push;

    assign o_out_valid       = (r_count != '0);
    assign o_out_data        = r_q[r_head];
    assign w_pop             = o_out_valid && !i_out_stall;
    assign w_count_after_pop = r_count - CNT_W'(w_pop);
    // Leave room for two tokens from the byte in the lex stage.
    assign w_room            = w_count_after_pop <= CNT_W'(QUEUE_DEPTH - 2);
    assign w_push            = w_fire ? w_push_cnt : 2'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (w_pop) begin
                r_head <= r_head + QUEUE_AW'(1);
            end
            r_tail  <= r_tail + QUEUE_AW'(w_push);
            r_count <= w_count_after_pop + CNT_W'(w_push);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push != 2'd0) begin
            r_q[r_tail] <= w_slot0;
        end
        if (w_push == 2'd2) begin
            r_q[r_tail + QUEUE_AW'(1)] <= w_slot1;
        end
    end

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("result queue overfilled");

    a_eos_resets_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_eos) |=> (r_mode == MODE_DEFAULT && r_byte_position == '0))
        else $error("mode or position not restarted after end of source");

    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.token_kind <= TK_MAX))
        else $error("token kind out of range");

    a_pair_has_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_push_cnt == 2'd2) |-> (r_mode != MODE_DEFAULT && r_mode != MODE_STR))
        else $error("two tokens from a byte without a pending token");

    a_stall_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_count == CNT_W'(QUEUE_DEPTH) && i_out_stall) |-> o_in_stall)
        else $error("lex stage fired into a full queue");

endmodule

// ===== test/script_lexer_tb.sv =====
// script_lexer_tb: self-checking testbench for the script lexer; a table of directed bytes,
// then random source texts, checked token by token against a predictor held here.
// Depends on rtl/core/slex_pkg.sv and rtl/core/script_lexer.sv.
module script_lexer_tb;
    import slex_pkg::*;

    localparam int TEXT_CAP     = 255;    // MAX_TEXT_LEN of the instance
    localparam int STIM_TARGET  = 1700;   // counted random bytes
    localparam int CALM_TAIL    = 250;    // final bytes sent with no idling
    localparam int QUIET_LIMIT  = 1000;   // cycles with no beat before giving up
    localparam int DRAIN_CYCLES = 20;

    // One row of the directed table; typed rows carry their token by hand.
    typedef struct {
        t_lex_in  beat;
        logic     typed;
        t_lex_out tok;
    } t_source_row;

    logic     i_clk;
    logic     i_rst_n     = 1'b0;
    logic     i_in_valid  = 1'b0;
    t_lex_in  i_in_data   = '0;
    logic     i_out_stall = 1'b0;
    logic     o_in_stall;
    logic     o_out_valid;
    t_lex_out o_out_data;

    script_lexer i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor state: mirrors the lexer's mode registers.
    // ------------------------------------------------------------------
    t_lex_mode   lx_mode    = MODE_DEFAULT;
    logic [7:0]  op_first   = '0;
    logic        op_second  = 1'b0;
    logic        op_refined = 1'b0;
    int unsigned text_cnt   = 0;          // capped at TEXT_CAP + 1
    logic [7:0]  id_head [PREFIX_DEPTH];  // first identifier bytes
    logic [31:0] num_acc    = '0;
    logic [15:0] tok_start  = '0;
    logic [15:0] src_pos    = '0;

    t_lex_out expected_tokens [$];

    string      reserved_words [6] = '{"script", "end", "while", "if", "else", "def"};
    logic [4:0] reserved_kinds [6] = '{TK_SCRIPT, TK_END, TK_WHILE, TK_IF, TK_ELSE, TK_DEF};
    string      op_chars    = "+-*/%<>=!|&";
    string      punct_chars = "()[],";
    string      blank_chars = " \t\n\r";

    // Bookkeeping for the summary and the verdict.
    int          mismatch_count = 0;
    int          tokens_checked = 0;
    int          bytes_sent     = 0;
    int          sources_sent   = 0;
    int          stim_count     = 0;
    int          over_length    = 0;
    int          saturated      = 0;
    int          last_run_len   = 0;      // tokens queued for the latest byte
    logic [31:0] kinds_seen     = '0;
    logic        idle_on        = 1'b0;
    int          stall_left     = 0;
    int          quiet_cycles   = 0;

    t_lex_in     src_bytes [$];           // source text being assembled
    t_source_row source_rows [$];

    function automatic logic op_byte(logic [7:0] c);
        return c == "+" || c == "-" || c == "*" || c == "/" || c == "%" || c == "<" ||
               c == ">" || c == "=" || c == "!" || c == "|" || c == "&";
    endfunction

    function automatic logic digit_byte(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic letter_byte(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    // Returns 1 and the kind when c is a parenthesis, bracket or comma.
    function automatic logic punct_code(logic [7:0] c, output logic [4:0] kind);
        kind = TK_COMMA;
        case (c)
            "(": kind = TK_LPAREN;
            ")": kind = TK_RPAREN;
            "[": kind = TK_LBRACKET;
            "]": kind = TK_RBRACKET;
            ",": kind = TK_COMMA;
            default: return 1'b0;
        endcase
        return 1'b1;
    endfunction

    function automatic logic [4:0] op_code(logic [7:0] first, logic refined);
        case (first)
            "+": return TK_PLUS;
            "-": return TK_MINUS;
            "*": return TK_STAR;
            "/": return TK_SLASH;
            "%": return TK_PERCENT;
            "<": return refined ? TK_LE : TK_LT;
            ">": return refined ? TK_GE : TK_GT;
            "=": return refined ? TK_EQ : TK_ASSIGN;
            "!": return refined ? TK_NE : TK_NOT;
            "|": return TK_OR;
            default: return TK_AND;
        endcase
    endfunction

    function automatic t_lex_out make_tok(logic [4:0] kind, logic [15:0] start,
                                          logic [7:0] len, logic [31:0] value, logic over);
        t_lex_out t;
        t.token_kind   = kind;
        t.start_pos    = start;
        t.length       = len;
        t.number_value = value;
        t.too_long     = over;
        t.last_of_run  = 1'b0;
        return t;
    endfunction

    // Text tokens report a capped length and flag the overrun.
    function automatic t_lex_out text_tok(logic [4:0] kind, logic [31:0] value);
        logic [7:0] len;
        len = (text_cnt > TEXT_CAP) ? 8'(TEXT_CAP) : 8'(text_cnt);
        return make_tok(kind, tok_start, len, value, text_cnt > TEXT_CAP);
    endfunction

    function automatic t_lex_out op_tok();
        return make_tok(op_code(op_first, op_refined), tok_start,
                        op_second ? 8'd2 : 8'd1, 32'd0, 1'b0);
    endfunction

    // A word is reserved only when its whole text equals one of the six words.
    function automatic t_lex_out word_tok();
        logic [4:0] kind;
        logic       same;
        int         w;
        int         j;
        kind = TK_IDENT;
        for (w = 0; w < 6; w++) begin
            if (text_cnt == reserved_words[w].len()) begin
                same = 1'b1;
                for (j = 0; j < reserved_words[w].len(); j++)
                    if (id_head[j] != reserved_words[w][j]) same = 1'b0;
                if (same) kind = reserved_kinds[w];
            end
        end
        return text_tok(kind, 32'd0);
    endfunction

    function automatic void grow_text();
        if (text_cnt <= TEXT_CAP) text_cnt++;
    endfunction

    // Advance the predictor by one accepted byte and queue the tokens it yields.
    task automatic lex_byte(input t_lex_in beat);
        t_lex_out   run [$];
        t_lex_out   t;
        logic [7:0] c;
        logic [4:0] pk;
        logic       redo;
        int         pass;
        logic [35:0] wide;
        c = beat.ch;
        pass = 0;
        redo = 1'b1;
        // A byte that ends a pending operator, number or identifier is classified a second time.
        while (redo && pass < 2) begin
            redo = 1'b0;
            pass++;
            case (lx_mode)
                MODE_OP: begin
                    if (op_byte(c) && !op_second) begin
                        op_second  = 1'b1;
                        op_refined = (c == "=") && (op_first == "<" || op_first == ">" ||
                                                    op_first == "=" || op_first == "!");
                    end else begin
                        run.push_back(op_tok());
                        lx_mode = MODE_DEFAULT;
                        redo = 1'b1;
                    end
                end
                MODE_NUM: begin
                    if (digit_byte(c)) begin
                        wide = 36'(num_acc) * 36'd10 + 36'(c - 8'h30);
                        num_acc = (wide > 36'hFFFF_FFFF) ? 32'hFFFF_FFFF : wide[31:0];
                        grow_text();
                    end else begin
                        run.push_back(text_tok(TK_NUMBER, num_acc));
                        lx_mode = MODE_DEFAULT;
                        redo = 1'b1;
                    end
                end
                MODE_ID: begin
                    if (letter_byte(c) || digit_byte(c)) begin
                        if (text_cnt < PREFIX_DEPTH) id_head[text_cnt] = c;
                        grow_text();
                    end else begin
                        run.push_back(word_tok());
                        lx_mode = MODE_DEFAULT;
                        redo = 1'b1;
                    end
                end
                MODE_STR: begin
                    if (c == "\"") begin
                        run.push_back(text_tok(TK_STRING, 32'd0));
                        lx_mode = MODE_DEFAULT;
                    end else begin
                        grow_text();
                    end
                end
                default: begin
                    lx_mode = MODE_DEFAULT;
                    if (op_byte(c)) begin
                        op_first   = c;
                        op_second  = 1'b0;
                        op_refined = 1'b0;
                        tok_start  = src_pos;
                        lx_mode    = MODE_OP;
                    end else if (digit_byte(c)) begin
                        num_acc   = 32'(c - 8'h30);
                        text_cnt  = 1;
                        tok_start = src_pos;
                        lx_mode   = MODE_NUM;
                    end else if (punct_code(c, pk)) begin
                        run.push_back(make_tok(pk, src_pos, 8'd1, 32'd0, 1'b0));
                    end else if (letter_byte(c)) begin
                        id_head[0] = c;
                        text_cnt   = 1;
                        tok_start  = src_pos;
                        lx_mode    = MODE_ID;
                    end else if (c == "\"") begin
                        text_cnt  = 0;
                        tok_start = src_pos + 16'd1;
                        lx_mode   = MODE_STR;
                    end
                end
            endcase
        end
        // End of source flushes what is pending; an open string is dropped.
        if (beat.end_of_source) begin
            case (lx_mode)
                MODE_OP:  run.push_back(op_tok());
                MODE_NUM: run.push_back(text_tok(TK_NUMBER, num_acc));
                MODE_ID:  run.push_back(word_tok());
                default: ;
            endcase
            lx_mode = MODE_DEFAULT;
            src_pos = '0;
        end else begin
            src_pos = src_pos + 16'd1;
        end
        foreach (run[i]) begin
            t = run[i];
            t.last_of_run = (i == run.size() - 1);
            expected_tokens.push_back(t);
        end
        last_run_len = run.size();
    endtask

    // ------------------------------------------------------------------
    // Output side: check each token beat, stall in random bursts.
    // ------------------------------------------------------------------
    task automatic report_failure(input string what, input t_lex_out want, input t_lex_out got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%s: want kind %0d pos %0d len %0d val %0d long %0b last %0b",
                     what, want.token_kind, want.start_pos, want.length, want.number_value,
                     want.too_long, want.last_of_run,
                     " | got kind %0d pos %0d len %0d val %0d long %0b last %0b",
                     got.token_kind, got.start_pos, got.length, got.number_value,
                     got.too_long, got.last_of_run);
    endtask

    task automatic check_token(input t_lex_out got);
        t_lex_out want;
        if (expected_tokens.size() == 0) begin
            report_failure("token with nothing pending", '0, got);
        end else begin
            want = expected_tokens.pop_front();
            if (got.token_kind !== want.token_kind || got.start_pos !== want.start_pos ||
                got.length !== want.length || got.number_value !== want.number_value ||
                got.too_long !== want.too_long || got.last_of_run !== want.last_of_run)
                report_failure("token mismatch", want, got);
            tokens_checked++;
            if (got.token_kind <= TK_MAX) kinds_seen[got.token_kind] = 1'b1;
            if (got.too_long === 1'b1) over_length++;
            if (got.token_kind == TK_NUMBER && got.number_value == 32'hFFFF_FFFF) saturated++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) check_token(o_out_data);
        // Now and then, while idling is on, hold stall for a burst.
        if (stall_left > 0) begin
            stall_left--;
        end else if (idle_on && $urandom_range(0, 11) == 0) begin
            stall_left = $urandom_range(1, 4);
        end
        i_out_stall <= (stall_left > 0);
    end

    // Give up when no beat moves on either side for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no beat for %0d cycles, %0d tokens pending",
                     quiet_cycles, expected_tokens.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Input side.
    // ------------------------------------------------------------------
    // Drive one byte, with an optional idle burst first, and hold it until taken.
    task automatic push_byte(input t_lex_in beat);
        if (idle_on && $urandom_range(0, 9) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= beat;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        lex_byte(beat);
        bytes_sent++;
    endtask

    function automatic t_source_row plain_row(logic [7:0] c, logic eos);
        t_source_row r;
        r.beat.ch            = c;
        r.beat.end_of_source = eos;
        r.typed              = 1'b0;
        r.tok                = '0;
        return r;
    endfunction

    function automatic t_source_row typed_row(logic [7:0] c, logic eos, logic [4:0] kind,
                                              logic [15:0] start, logic [31:0] value);
        t_source_row r;
        r = plain_row(c, eos);
        r.typed = 1'b1;
        r.tok = make_tok(kind, start, 8'd1, value, 1'b0);
        r.tok.last_of_run = 1'b1;
        return r;
    endfunction

    task automatic put(input logic [7:0] c);
        t_lex_in b;
        b.ch = c;
        b.end_of_source = 1'b0;
        src_bytes.push_back(b);
    endtask

    task automatic put_text(input string s);
        int k;
        for (k = 0; k < s.len(); k++) put(s[k]);
    endtask

    function automatic logic [7:0] rand_letter();
        int r;
        r = $urandom_range(0, 51);
        return (r < 26) ? 8'(8'h61 + r) : 8'(8'h41 + r - 26);
    endfunction

    function automatic logic [7:0] rand_digit();
        return 8'(8'h30 + $urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] rand_alnum();
        return ($urandom_range(0, 3) == 0) ? rand_digit() : rand_letter();
    endfunction

    // Any byte but the closing quote, so strings stay well formed.
    function automatic logic [7:0] rand_str_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == "\"") b = 8'($urandom_range(0, 33));
        return b;
    endfunction

    // Append one token's text, mostly well formed, sometimes noise.
    task automatic append_lexeme();
        int    r;
        int    n;
        int    k;
        string w;
        r = $urandom_range(0, 99);
        if (r < 20) begin
            n = $urandom_range(1, 3);
            for (k = 0; k < n; k++) begin
                if (k > 0 && $urandom_range(0, 2) == 0) put("=");
                else put(op_chars[$urandom_range(0, 10)]);
            end
        end else if (r < 30) begin
            put(punct_chars[$urandom_range(0, 4)]);
        end else if (r < 45) begin
            n = $urandom_range(1, 12);
            repeat (n) put(rand_digit());
        end else if (r < 65) begin
            n = $urandom_range(0, 9);
            w = reserved_words[$urandom_range(0, 5)];
            if (n < 5) begin
                put_text(w);
            end else if (n < 7) begin
                // Near misses: extra letter, cut short, or capitalized.
                case ($urandom_range(0, 2))
                    0: w = {w, "s"};
                    1: w = w.substr(0, w.len() - 2);
                    default: w[0] = w[0] - 8'h20;
                endcase
                put_text(w);
            end else begin
                put(rand_letter());
                repeat ($urandom_range(0, 7)) put(rand_alnum());
            end
        end else if (r < 78) begin
            put("\"");
            repeat ($urandom_range(0, 10)) put(rand_str_byte());
            put("\"");
        end else if (r < 90) begin
            put(blank_chars[$urandom_range(0, 3)]);
        end else begin
            put(8'($urandom_range(0, 255)));
        end
    endtask

    // Mark the last byte as end of source and send the whole text.
    task automatic send_source(input logic counted);
        t_lex_in b;
        b = src_bytes.pop_back();
        b.end_of_source = 1'b1;
        src_bytes.push_back(b);
        if (counted) stim_count += src_bytes.size();
        foreach (src_bytes[i]) push_byte(src_bytes[i]);
        src_bytes.delete();
        sources_sent++;
    endtask

    // ------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------
    initial begin
        // Directed table: punctuation right after reset, ignored extremes,
        // a refined operator cut by a third byte, a second byte that is not
        // '=', a byte that ends one token and starts another, a reserved word,
        // a string with a high byte, flushes at end of source and a dropped
        // open string.
        source_rows.push_back(typed_row("(", 1'b0, TK_LPAREN, 16'd0, 32'd0));
        source_rows.push_back(typed_row(")", 1'b0, TK_RPAREN, 16'd1, 32'd0));
        source_rows.push_back(plain_row(8'h00, 1'b0));
        source_rows.push_back(plain_row(8'hFF, 1'b0));
        source_rows.push_back(plain_row("<", 1'b0));
        source_rows.push_back(plain_row("=", 1'b0));
        source_rows.push_back(plain_row("=", 1'b0));
        source_rows.push_back(plain_row("!", 1'b0));
        source_rows.push_back(plain_row("9", 1'b0));
        source_rows.push_back(plain_row("9", 1'b0));
        source_rows.push_back(plain_row("i", 1'b0));
        source_rows.push_back(plain_row("f", 1'b0));
        source_rows.push_back(plain_row(" ", 1'b0));
        source_rows.push_back(plain_row("\"", 1'b0));
        source_rows.push_back(plain_row(8'h80, 1'b0));
        source_rows.push_back(plain_row("\"", 1'b0));
        source_rows.push_back(plain_row("+", 1'b0));
        source_rows.push_back(plain_row("d", 1'b0));
        source_rows.push_back(plain_row("e", 1'b0));
        source_rows.push_back(plain_row("f", 1'b1));
        source_rows.push_back(plain_row("\"", 1'b0));
        source_rows.push_back(plain_row("a", 1'b1));
        source_rows.push_back(typed_row("4", 1'b1, TK_NUMBER, 16'd0, 32'd4));
        source_rows.push_back(typed_row("&", 1'b1, TK_AND, 16'd0, 32'd0));
        source_rows.push_back(typed_row(",", 1'b0, TK_COMMA, 16'd0, 32'd0));
        source_rows.push_back(typed_row("]", 1'b1, TK_RBRACKET, 16'd1, 32'd0));

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        idle_on = 1'b1;

        foreach (source_rows[i]) begin
            push_byte(source_rows[i].beat);
            // Typed rows replace what the predictor queued for this byte.
            if (source_rows[i].typed) begin
                repeat (last_run_len) void'(expected_tokens.pop_back());
                expected_tokens.push_back(source_rows[i].tok);
            end
        end

        // Over-length texts: a saturating number past the cap, a word exactly
        // at the cap, a string one byte past it.
        repeat (260) put(rand_digit());
        put(" ");
        put(rand_letter());
        repeat (TEXT_CAP - 1) put(rand_alnum());
        put(" ");
        put("\"");
        repeat (TEXT_CAP + 1) put(rand_str_byte());
        put("\"");
        send_source(1'b1);

        while (stim_count < STIM_TARGET) begin
            if (stim_count > STIM_TARGET - CALM_TAIL) idle_on = 1'b0;
            repeat ($urandom_range(1, 25)) append_lexeme();
            if ($urandom_range(0, 9) == 0) begin
                put("\"");
                put(rand_letter());
            end
            send_source(1'b1);
        end
        idle_on = 1'b0;
        i_in_valid <= 1'b0;

        // Drain the tokens still in flight, then allow for the pipeline.
        while (expected_tokens.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d bytes in %0d directed and random sources; %0d tokens",
                 bytes_sent, sources_sent, tokens_checked);
        $display("token kinds seen %0d of 29, over-length texts %0d, saturated numbers %0d",
                 $countones(kinds_seen), over_length, saturated);
        if (mismatch_count == 0 && expected_tokens.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("%0d mismatches, %0d tokens never delivered",
                     mismatch_count, expected_tokens.size());
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
